[hdl/ggc_pkg.sv]
// Shared types and constants for the greedy graph coloring block.
// Used by ggc_adj_store, ggc_taken_unit and the top level; depends on nothing else.
package ggc_pkg;

  // Field widths fixed by the stream and configuration formats.
  localparam int VID_W   = 6;   // vertex_a, vertex_b, vertex_id, color
  localparam int CMD_W   = 2;   // command carried in tuser
  localparam int CFG_W   = 7;   // vertex_count register
  localparam int TDATA_W = 16;  // both tdata buses, padded to whole bytes
  localparam int PAD_W   = TDATA_W - 2 * VID_W;

  // Commands of an input transfer.
  typedef enum logic [CMD_W-1:0] {
    CMD_ADD   = 2'd0,
    CMD_COLOR = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  // Request to the adjacency store.
  typedef struct packed {
    logic             rd;
    logic             wr;
    logic             clr;
    logic [VID_W-1:0] addr;
  } adj_req_t;

  // Control of the shared taken-color unit.
  typedef struct packed {
    logic             clr;
    logic             set;
    logic [VID_W-1:0] set_idx;
    logic [VID_W-1:0] test_idx;
  } taken_ctl_t;

endpackage

[hdl/ggc_adj_store.sv]
// Adjacency matrix store: one row per vertex in a single-port memory,
// with a per-row valid bit so that reset and clear empty it at once.
// Depends on ggc_pkg.
module ggc_adj_store #(
  parameter int MAX_VERTICES = 64
) (
  input  logic                    clk,
  input  logic                    rst,
  input  ggc_pkg::adj_req_t       req,
  input  logic [MAX_VERTICES-1:0] wr_row,
  output logic [MAX_VERTICES-1:0] rd_row
);

  localparam int IDX_W = $clog2(MAX_VERTICES);

  logic [MAX_VERTICES-1:0] mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] row_valid;
  logic [MAX_VERTICES-1:0] mem_q;
  logic                    valid_q;
  logic [IDX_W-1:0]        addr;

  assign addr = req.addr[IDX_W-1:0];

  // Row storage: one write or one read per cycle, read data registered.
  always_ff @(posedge clk) begin
    if (req.wr) begin
      mem[addr] <= wr_row;
    end
    if (req.rd) begin
      mem_q <= mem[addr];
    end
  end

  // Valid bits: a row that was never written since the last clear reads as empty.
  always_ff @(posedge clk) begin
    if (rst || req.clr) begin
      row_valid <= '0;
      valid_q   <= 1'b0;
    end else begin
      if (req.wr) begin
        row_valid[addr] <= 1'b1;
      end
      if (req.rd) begin
        valid_q <= row_valid[addr];
      end
    end
  end

  assign rd_row = valid_q ? mem_q : '0;

endmodule

[hdl/ggc_color_ram.sv]
// Color memory: the color given to each vertex in the current pass.
// One write port and one registered read port; no reset. Depends on nothing.
module ggc_color_ram #(
  parameter int MAX_VERTICES = 64,
  parameter int DATA_W       = 6
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(MAX_VERTICES)-1:0]  waddr,
  input  logic [DATA_W-1:0]                wdata,
  input  logic                             re,
  input  logic [$clog2(MAX_VERTICES)-1:0]  raddr,
  output logic [DATA_W-1:0]                rdata
);

  logic [DATA_W-1:0] mem [MAX_VERTICES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/ggc_taken_unit.sv]
// Taken-color unit: a mask of colors held by earlier neighbors, set one bit
// a cycle during the neighbor scan and tested one bit a cycle during the
// free-color search. Depends on ggc_pkg.
module ggc_taken_unit #(
  parameter int MAX_VERTICES = 64
) (
  input  logic                  clk,
  input  ggc_pkg::taken_ctl_t   ctl,
  output logic                  bit_taken
);

  localparam int IDX_W = $clog2(MAX_VERTICES);

  logic [MAX_VERTICES-1:0] taken;

  // Clear at the start of each vertex, then mark one neighbor color per cycle.
  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      taken <= '0;
    end else if (ctl.set) begin
      taken[ctl.set_idx[IDX_W-1:0]] <= 1'b1;
    end
  end

  assign bit_taken = taken[ctl.test_idx[IDX_W-1:0]];

endmodule

[hdl/greedy_graph_coloring_top.sv]
// Top level of the first-fit greedy graph coloring block: sequencer,
// input and output stream ports, configuration register.
// Depends on ggc_pkg, ggc_adj_store, ggc_color_ram and ggc_taken_unit.
//
//   Channel  Direction  Payload
//   s_axis   in         tuser = cmd; tdata = vertex_a, vertex_b
//   m_axis   out        tdata = vertex_id, color; tlast = last
//   cfg      in         cfg_wdata = vertex_count, written when cfg_wen is high
//
// An add-edge item does two read-modify-writes of the adjacency memory; a
// clear item empties the matrix. A color item colors each vertex v in turn
// with one row read, one color-memory read per lower-numbered vertex, and
// one test of the taken-color unit per color tried. The block takes one
// item at a time; a result waits in the output register while the sequencer
// goes on, and a full output register holds the sequencer. Reset empties
// the matrix at once through per-row valid bits.
module greedy_graph_coloring_top #(
  parameter int MAX_VERTICES = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [ggc_pkg::TDATA_W-1:0]  s_axis_tdata,  // [5:0] vertex_a, [11:6] vertex_b
  input  logic [ggc_pkg::CMD_W-1:0]    s_axis_tuser,  // [1:0] cmd
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [ggc_pkg::TDATA_W-1:0]  m_axis_tdata,  // [5:0] vertex_id, [11:6] color
  output logic                         m_axis_tlast,  // last
  input  logic                         cfg_wen,
  input  logic [ggc_pkg::CFG_W-1:0]    cfg_wdata      // vertex_count
);

  localparam int IDX_W = $clog2(MAX_VERTICES);
  localparam int CNT_W = $clog2(MAX_VERTICES + 1);
  localparam logic [MAX_VERTICES-1:0] ROW_BIT0 = 1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD_RD_A,
    ST_ADD_WR_A,
    ST_ADD_RD_B,
    ST_ADD_WR_B,
    ST_ROW_RD,
    ST_SCAN,
    ST_SEARCH,
    ST_EMIT
  } state_t;

  state_t                     state;
  logic [ggc_pkg::CFG_W-1:0]  vertex_count;
  logic [ggc_pkg::CFG_W-1:0]  eff_count;
  logic [CNT_W-1:0]           n_q;
  logic [IDX_W-1:0]           a_q;
  logic [IDX_W-1:0]           b_q;
  logic [IDX_W-1:0]           v;
  logic [IDX_W-1:0]           j;
  logic [IDX_W-1:0]           pend_j;
  logic                       pend;
  logic [IDX_W-1:0]           c;
  logic                       in_accept;
  ggc_pkg::cmd_t              in_cmd;
  logic [ggc_pkg::VID_W-1:0]  in_a;
  logic [ggc_pkg::VID_W-1:0]  in_b;
  logic                       add_ok;
  logic                       out_load;
  logic                       last_v;
  ggc_pkg::adj_req_t          adj_req;
  logic [MAX_VERTICES-1:0]    adj_wr_row;
  logic [MAX_VERTICES-1:0]    adj_rd_row;
  logic                       col_re;
  logic [ggc_pkg::VID_W-1:0]  col_rdata;
  ggc_pkg::taken_ctl_t        taken_ctl;
  logic                       bit_taken;

  // Configuration register; counts above the matrix size saturate.
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= ggc_pkg::CFG_W'(64);
    end else if (cfg_wen) begin
      vertex_count <= cfg_wdata;
    end
  end

  assign eff_count = (vertex_count > ggc_pkg::CFG_W'(MAX_VERTICES))
                     ? ggc_pkg::CFG_W'(MAX_VERTICES) : vertex_count;

  // Input decode.
  assign s_axis_tready = (state == ST_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign in_cmd        = ggc_pkg::cmd_t'(s_axis_tuser);
  assign in_a          = s_axis_tdata[ggc_pkg::VID_W-1:0];
  assign in_b          = s_axis_tdata[2*ggc_pkg::VID_W-1:ggc_pkg::VID_W];
  assign add_ok        = ({1'b0, in_a} < eff_count) && ({1'b0, in_b} < eff_count);

  // Result handoff to the output register.
  assign out_load = (state == ST_EMIT) && (!m_axis_tvalid || m_axis_tready);
  assign last_v   = ((CNT_W'(v) + CNT_W'(1)) == n_q);

  // Adjacency store requests: row reads and read-modify-writes of edge bits.
  always_comb begin
    adj_req      = '0;
    adj_wr_row   = adj_rd_row;
    adj_req.clr  = in_accept && (in_cmd == ggc_pkg::CMD_CLEAR);
    case (state)
      ST_ADD_RD_A: begin
        adj_req.rd   = 1'b1;
        adj_req.addr = ggc_pkg::VID_W'(a_q);
      end
      ST_ADD_WR_A: begin
        adj_req.wr   = 1'b1;
        adj_req.addr = ggc_pkg::VID_W'(a_q);
        adj_wr_row   = adj_rd_row | (ROW_BIT0 << b_q);
      end
      ST_ADD_RD_B: begin
        adj_req.rd   = 1'b1;
        adj_req.addr = ggc_pkg::VID_W'(b_q);
      end
      ST_ADD_WR_B: begin
        adj_req.wr   = 1'b1;
        adj_req.addr = ggc_pkg::VID_W'(b_q);
        adj_wr_row   = adj_rd_row | (ROW_BIT0 << a_q);
      end
      ST_ROW_RD: begin
        adj_req.rd   = 1'b1;
        adj_req.addr = ggc_pkg::VID_W'(v);
      end
      default: begin
        adj_req.rd   = 1'b0;
      end
    endcase
  end

  // Taken-color unit control: clear per vertex, mark during the scan,
  // test the candidate color during the search.
  always_comb begin
    taken_ctl          = '0;
    taken_ctl.clr      = (state == ST_ROW_RD);
    taken_ctl.set      = (state == ST_SCAN) && pend && adj_rd_row[pend_j];
    taken_ctl.set_idx  = col_rdata;
    taken_ctl.test_idx = ggc_pkg::VID_W'(c);
  end

  assign col_re = (state == ST_SCAN) && (j != v);

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      m_axis_tvalid <= 1'b0;
      pend          <= 1'b0;
    end else begin
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
        m_axis_tdata  <= {{ggc_pkg::PAD_W{1'b0}}, ggc_pkg::VID_W'(c), ggc_pkg::VID_W'(v)};
        m_axis_tlast  <= last_v;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            a_q <= in_a[IDX_W-1:0];
            b_q <= in_b[IDX_W-1:0];
            n_q <= CNT_W'(eff_count);
            v   <= '0;
            case (in_cmd)
              ggc_pkg::CMD_ADD:   state <= add_ok ? ST_ADD_RD_A : ST_IDLE;
              ggc_pkg::CMD_COLOR: state <= (eff_count == '0) ? ST_IDLE : ST_ROW_RD;
              default:            state <= ST_IDLE;
            endcase
          end
        end
        ST_ADD_RD_A: state <= ST_ADD_WR_A;
        ST_ADD_WR_A: state <= ST_ADD_RD_B;
        ST_ADD_RD_B: state <= ST_ADD_WR_B;
        ST_ADD_WR_B: state <= ST_IDLE;
        ST_ROW_RD: begin
          j     <= '0;
          c     <= '0;
          pend  <= 1'b0;
          state <= ST_SCAN;
        end
        ST_SCAN: begin
          // Read the color of neighbor j; it is marked in the next cycle.
          if (j == v) begin
            pend  <= 1'b0;
            state <= ST_SEARCH;
          end else begin
            pend   <= 1'b1;
            pend_j <= j;
            j      <= j + IDX_W'(1);
          end
        end
        ST_SEARCH: begin
          if (bit_taken) begin
            c <= c + IDX_W'(1);
          end else begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_load) begin
            if (last_v) begin
              state <= ST_IDLE;
            end else begin
              v     <= v + IDX_W'(1);
              state <= ST_ROW_RD;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  ggc_adj_store #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_adj_store (
    .clk    (clk),
    .rst    (rst),
    .req    (adj_req),
    .wr_row (adj_wr_row),
    .rd_row (adj_rd_row)
  );

  ggc_color_ram #(
    .MAX_VERTICES (MAX_VERTICES),
    .DATA_W       (ggc_pkg::VID_W)
  ) u_color_ram (
    .clk   (clk),
    .we    (out_load),
    .waddr (v),
    .wdata (ggc_pkg::VID_W'(c)),
    .re    (col_re),
    .raddr (j),
    .rdata (col_rdata)
  );

  ggc_taken_unit #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_taken_unit (
    .clk       (clk),
    .ctl       (taken_ctl),
    .bit_taken (bit_taken)
  );

`ifndef SYNTH
  // The neighbor scan never passes the vertex being colored.
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (j <= v))
    else $error("neighbor index ran past the current vertex");

  // First fit never needs a color above the vertex number.
  a_color_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEARCH) |-> (c <= v))
    else $error("color search ran past the current vertex");

  // The transfer of the final vertex ends the coloring pass.
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (out_load && last_v) |=> (state == ST_IDLE && m_axis_tvalid && m_axis_tlast))
    else $error("coloring pass did not end after the final vertex");
`endif

endmodule
